// ----- design/c2us_pkg.sv -----
package c2us_pkg;

    // Width of the free-running cycle counter and of the accounting state.
    localparam int CNT_W     = 32;
    // Width of the microsecond total and of the result.
    localparam int US_W      = 32;
    // Width of the cycles-per-microsecond register.
    localparam int CPM_W     = 10;
    // Input and output stream widths.
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    // Divider step counter.
    localparam int CNT_IDX_W = $clog2(CNT_W);
    localparam logic [CNT_IDX_W-1:0] STEP_LAST = CNT_IDX_W'(CNT_W - 1);

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic update;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cfg_zero;
    } t_status;

endpackage

// ----- design/c2us_dp.sv -----
module c2us_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [c2us_pkg::CPM_W-1:0]    i_cfg_wdata,
    input  logic [c2us_pkg::IN_W-1:0]     i_snapshot,
    input  c2us_pkg::t_cmd                i_cmd,
    output c2us_pkg::t_status             o_status,
    output logic [c2us_pkg::US_W-1:0]     o_total
);

    logic [c2us_pkg::CPM_W-1:0] r_cpm;
    logic [c2us_pkg::CNT_W-1:0] r_last;
    logic [c2us_pkg::CNT_W-1:0] r_now;
    logic [c2us_pkg::CNT_W-1:0] r_quo;
    logic [c2us_pkg::CPM_W-1:0] r_rem;
    logic [c2us_pkg::US_W-1:0]  r_total;

    logic [c2us_pkg::CPM_W:0]   rem_sh;
    logic [c2us_pkg::CPM_W:0]   rem_diff;
    logic                       q_bit;
    logic [c2us_pkg::CNT_W-1:0] now;

    // The snapshot is cut to the counter width.
    assign now = c2us_pkg::CNT_W'(i_snapshot);

    // One restoring division step: shift in the next dividend bit and try to subtract.
    always_comb begin
        rem_sh   = {r_rem, r_quo[c2us_pkg::CNT_W-1]};
        rem_diff = rem_sh - {1'b0, r_cpm};
        q_bit    = (rem_sh >= {1'b0, r_cpm});
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpm <= '0;
        end else if (i_cfg_we) begin
            r_cpm <= i_cfg_wdata;
        end
    end

    // Accounting state: last accounted cycle and microsecond total.
    // Since delta = q * div + rem, the new last value is the snapshot minus the remainder.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_total <= '0;
        end else if (i_cmd.update) begin
            r_last  <= r_now - c2us_pkg::CNT_W'(r_rem);
            r_total <= r_total + c2us_pkg::US_W'(r_quo);
        end
    end

    // Divider registers: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= now;
            r_quo <= now - r_last;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[c2us_pkg::CNT_W-2:0], q_bit};
            r_rem <= q_bit ? rem_diff[c2us_pkg::CPM_W-1:0] : rem_sh[c2us_pkg::CPM_W-1:0];
        end
    end

    assign o_status.cfg_zero = (r_cpm == '0);
    assign o_total           = r_total;

endmodule

// ----- design/c2us_ctrl.sv -----
module c2us_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    input  c2us_pkg::t_status   i_status,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output c2us_pkg::t_cmd      o_cmd
);

    c2us_pkg::t_state               r_state;
    c2us_pkg::t_state               n_state;
    logic [c2us_pkg::CNT_IDX_W-1:0] r_count;
    logic [c2us_pkg::CNT_IDX_W-1:0] n_count;
    logic                           r_valid;
    logic                           n_valid;
    logic                           out_free;

    // The result register can take a new value when empty or being drained.
    assign out_free = !r_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            c2us_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.cfg_zero ? c2us_pkg::ST_EMIT : c2us_pkg::ST_DIV;
                end
            end
            c2us_pkg::ST_DIV: begin
                if (r_count == '0) begin
                    n_state = c2us_pkg::ST_FINISH;
                end
            end
            c2us_pkg::ST_FINISH,
            c2us_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = c2us_pkg::ST_IDLE;
                end
            end
            default: n_state = c2us_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            c2us_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            c2us_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            c2us_pkg::ST_FINISH: begin
                o_cmd.update = out_free;
                o_cmd.emit   = out_free;
            end
            c2us_pkg::ST_EMIT: begin
                o_cmd.emit = out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    // Step counter and result valid flag.
    always_comb begin
        n_count = r_count;
        if (o_cmd.load) begin
            n_count = c2us_pkg::STEP_LAST;
        end else if (o_cmd.step) begin
            n_count = r_count - 1'b1;
        end
        n_valid = o_cmd.emit || (r_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c2us_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;

endmodule

// ----- design/cycle_to_microsecond_accumulator.sv -----
// Channel    Direction  Payload
// s_axis     in         tdata[31:0] = cycle_snapshot
// m_axis     out        tdata[31:0] = uptime_microseconds
// cfg        in         wdata[9:0]  = cycles_per_microsecond
//
// With a nonzero divisor a snapshot holds the block through the accepting load cycle,
// 32 steps of the bit-serial restoring divider and one update; the update and the
// result wait until the result register is free. With a zero divisor the total is
// not updated; it is emitted unchanged once the result register is free.
// Reset is synchronous and active low; it clears the divisor and both accounting registers.
// A new snapshot is accepted while the previous result waits; the update is held until
// the result register is free.
module cycle_to_microsecond_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [c2us_pkg::IN_W-1:0]      i_s_axis_tdata,   // [31:0] cycle_snapshot
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [c2us_pkg::OUT_W-1:0]     o_m_axis_tdata,   // [31:0] uptime_microseconds
    input  logic                           i_cfg_we,
    input  logic [c2us_pkg::CPM_W-1:0]     i_cfg_wdata
);

    c2us_pkg::t_cmd             cmd;
    c2us_pkg::t_status          status;
    logic [c2us_pkg::US_W-1:0]  total;

    // Sequencer.
    c2us_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // Divider and accounting registers.
    c2us_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_snapshot  (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_total     (total)
    );

    assign o_m_axis_tdata = c2us_pkg::OUT_W'(total);

`ifndef SYNTHESIS
    // Load, divide, update and idle phases never overlap.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.step, cmd.update}))
        else $error("overlapping datapath commands");

    // No snapshot is accepted while the divider runs.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step |-> !o_s_axis_tready)
        else $error("snapshot accepted during division");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("pending result overwritten");

    // The total only changes together with a new result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cmd.emit |=> $stable(o_m_axis_tdata))
        else $error("total changed without a result");
`endif

endmodule
